// ===== hdl/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared constants, types and codes of the first-fit pool allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int POOL_BYTES   = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int ALIGN_BYTES  = 4;
    localparam int HDR_BYTES    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int GRANULES     = (POOL_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int GRAN_W       = $clog2(GRANULES);
    localparam int ALIGN_W      = $clog2(ALIGN_BYTES);
    localparam int LEN_W        = $clog2(POOL_BYTES) + 1;
    localparam int OFF_W        = LEN_W + 1;
    localparam int SIZE_W       = 16;
    localparam int NEED_W       = SIZE_W + 1;
    localparam int SUM_W        = NEED_W + 1;
    localparam int STEP_W       = GRAN_W + 1;
    localparam int ADDR_W       = 12;

    typedef enum logic [1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_MERGE  = 2'd2,
        K_REINIT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADADDR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_AL_RD,
        S_AL_CHK,
        S_AL_SPLIT,
        S_FR_CHK,
        S_MG_RD,
        S_MG_CHK,
        S_MG_NXT,
        S_MG_NCHK,
        S_MG_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic             used;
        logic [LEN_W-1:0] len;
    } t_seg;

    typedef struct packed {
        logic              en;
        logic [GRAN_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [GRAN_W-1:0] addr;
        t_seg              data;
    } t_wr_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] granted_address;
    } t_res;

endpackage

// ===== hdl/ffpa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_req_if / ffpa_rsp_if
// request and response channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface ffpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] request_size;
    logic [11:0] block_address;
    modport source (output valid, kind, request_size, block_address, input ready);
    modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

interface ffpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] granted_address;
    modport source (output valid, status, granted_address, input ready);
    modport sink (input valid, status, granted_address, output ready);
endinterface

// ===== hdl/first_fit_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// first-fit pool allocator over an address-ordered segment table
//
//   channel  dir  payload
//   i_req    in   kind, request_size, block_address
//   o_rsp    out  status, granted_address
//
// free reads and checks one table entry; allocate walks the segments, one
// table read and one check per segment walked, then writes the hit and, on a
// split, the free rest; merge reads each segment and, for a free one, each
// free neighbor it absorbs, all through the single table read port.
// after reset and on reinit a sweep rebuilds every table entry; no
// request is taken meanwhile. a waiting response stalls the next request
// only once that request has finished.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator
    import ffpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp
);
    t_rd_req rd;
    t_wr_req wr;
    t_seg    q;
    t_res    res;
    logic    res_valid;
    logic    res_ready;
    logic    r_ov;
    t_res    r_out;

    ffpa_ram u_ram (
        .i_clk (i_clk),
        .i_rd  (rd),
        .i_wr  (wr),
        .o_q   (q)
    );

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_rd        (rd),
        .o_wr        (wr),
        .i_q         (q)
    );

    assign res_ready = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ready) begin
            r_ov <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.granted_address = r_out.granted_address;
endmodule

// ===== hdl/ffpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ram
// segment table, one write and one registered read port
// ----------------------------------------------------------------------------
module ffpa_ram
    import ffpa_pkg::*;
(
    input  logic    i_clk,
    input  t_rd_req i_rd,
    input  t_wr_req i_wr,
    output t_seg    o_q
);
    t_seg r_mem [GRANULES];
    t_seg r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q <= r_mem[i_rd.addr];
        end
    end

    assign o_q = r_q;
endmodule

// ===== hdl/ffpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ctrl
// request sequencer: segment walk, split, free, merge and clearing sweep
// ----------------------------------------------------------------------------
module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    ffpa_req_if.sink i_req,
    output logic    o_res_valid,
    output t_res    o_res,
    input  logic    i_res_ready,
    output t_rd_req o_rd,
    output t_wr_req o_wr,
    input  t_seg    i_q
);
    t_state             r_state, n_state;
    logic [GRAN_W-1:0]  r_cidx, n_cidx;
    logic               r_pend, n_pend;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [LEN_W-1:0]   r_rest, n_rest;
    logic [OFF_W-1:0]   r_len, n_len;
    t_res               r_res, n_res;

    logic [NEED_W-1:0]  need_raw;
    logic [LEN_W-1:0]   rest;
    logic [SUM_W-1:0]   split_at;
    logic [OFF_W-1:0]   nxt;
    logic [ADDR_W-1:0]  seg_addr;
    logic               fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cidx  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cidx  <= n_cidx;
            r_pend  <= n_pend;
        end
        r_off   <= n_off;
        r_steps <= n_steps;
        r_need  <= n_need;
        r_rest  <= n_rest;
        r_len   <= n_len;
        r_res   <= n_res;
    end

    assign need_raw = {1'b0, i_req.request_size} + NEED_W'(HDR_BYTES + ALIGN_BYTES - 1);
    assign fits     = !i_q.used && ({{(NEED_W-LEN_W){1'b0}}, i_q.len} >= r_need);
    assign rest     = i_q.len - r_need[LEN_W-1:0];
    assign split_at = SUM_W'(r_off) + SUM_W'(r_need);
    assign nxt      = r_off + r_len;
    assign seg_addr = i_req.block_address - ADDR_W'(HDR_BYTES);

    always_comb begin
        n_state = r_state;
        n_cidx  = r_cidx;
        n_pend  = r_pend;
        n_off   = r_off;
        n_steps = r_steps;
        n_need  = r_need;
        n_rest  = r_rest;
        n_len   = r_len;
        n_res   = r_res;
        o_rd    = '0;
        o_wr    = '0;
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        o_res   = r_res;

        unique case (r_state)
            S_CLR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_cidx;
                o_wr.data = '0;
                if (r_cidx == '0) begin
                    o_wr.data.start = 1'b1;
                    o_wr.data.len   = LEN_W'(POOL_BYTES);
                end
                n_cidx = r_cidx + 1'b1;
                if (r_cidx == GRAN_W'(GRANULES - 1)) begin
                    n_cidx  = '0;
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                n_res   = '{status: ST_OK, granted_address: '0};
                n_off   = '0;
                n_steps = '0;
                if (i_req.valid) begin
                    unique case (t_kind'(i_req.kind))
                        K_ALLOC: begin
                            n_need  = need_raw & ~NEED_W'(ALIGN_BYTES - 1);
                            n_state = S_AL_RD;
                        end
                        K_FREE: begin
                            if (i_req.block_address < ADDR_W'(HDR_BYTES) ||
                                seg_addr[ALIGN_W-1:0] != '0) begin
                                n_res.status = ST_BADADDR;
                                n_state      = S_DONE;
                            end else begin
                                o_rd.en   = 1'b1;
                                o_rd.addr = GRAN_W'(seg_addr >> ALIGN_W);
                                n_off     = OFF_W'(seg_addr);
                                n_state   = S_FR_CHK;
                            end
                        end
                        K_MERGE: n_state = S_MG_RD;
                        default: begin
                            n_pend  = 1'b1;
                            n_state = S_CLR;
                        end
                    endcase
                end
            end
            S_AL_RD: begin
                if (r_off >= OFF_W'(POOL_BYTES) || r_steps >= STEP_W'(GRANULES)) begin
                    n_res.status = ST_NOFIT;
                    n_state      = S_DONE;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = GRAN_W'(r_off >> ALIGN_W);
                    n_state   = S_AL_CHK;
                end
            end
            S_AL_CHK: begin
                o_wr.addr = GRAN_W'(r_off >> ALIGN_W);
                if (i_q.len == '0) begin
                    n_res.status = ST_NOFIT;
                    n_state      = S_DONE;
                end else if (fits) begin
                    o_wr.en   = 1'b1;
                    o_wr.data = '{start: i_q.start, used: 1'b1, len: i_q.len};
                    n_res.granted_address = ADDR_W'(r_off + OFF_W'(HDR_BYTES));
                    if (rest <= LEN_W'(HDR_BYTES)) begin
                        n_state = S_DONE;
                    end else begin
                        o_wr.data.len = r_need[LEN_W-1:0];
                        n_rest  = rest;
                        n_state = S_AL_SPLIT;
                    end
                end else begin
                    n_off   = r_off + OFF_W'(i_q.len);
                    n_steps = r_steps + 1'b1;
                    n_state = S_AL_RD;
                end
            end
            S_AL_SPLIT: begin
                o_wr.en   = split_at < SUM_W'(POOL_BYTES);
                o_wr.addr = GRAN_W'(split_at >> ALIGN_W);
                o_wr.data = '{start: 1'b1, used: 1'b0, len: r_rest};
                n_state   = S_DONE;
            end
            S_FR_CHK: begin
                if (!i_q.start) begin
                    n_res.status = ST_BADADDR;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = GRAN_W'(r_off >> ALIGN_W);
                    o_wr.data = '{start: 1'b1, used: 1'b0, len: i_q.len};
                end
                n_state = S_DONE;
            end
            S_MG_RD: begin
                if (r_off >= OFF_W'(POOL_BYTES) || r_steps >= STEP_W'(GRANULES)) begin
                    n_state = S_DONE;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = GRAN_W'(r_off >> ALIGN_W);
                    n_state   = S_MG_CHK;
                end
            end
            S_MG_CHK: begin
                n_len = OFF_W'(i_q.len);
                if (i_q.len == '0) begin
                    n_state = S_DONE;
                end else if (i_q.used) begin
                    n_off   = r_off + OFF_W'(i_q.len);
                    n_steps = r_steps + 1'b1;
                    n_state = S_MG_RD;
                end else begin
                    n_state = S_MG_NXT;
                end
            end
            S_MG_NXT: begin
                if (nxt >= OFF_W'(POOL_BYTES) || nxt[ALIGN_W-1:0] != '0) begin
                    n_state = S_MG_END;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = GRAN_W'(nxt >> ALIGN_W);
                    n_state   = S_MG_NCHK;
                end
            end
            S_MG_NCHK: begin
                if (!i_q.start || i_q.used || i_q.len == '0) begin
                    n_state = S_MG_END;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = GRAN_W'(nxt >> ALIGN_W);
                    o_wr.data = '0;
                    n_len     = r_len + OFF_W'(i_q.len);
                    n_state   = S_MG_NXT;
                end
            end
            S_MG_END: begin
                o_wr.en   = 1'b1;
                o_wr.addr = GRAN_W'(r_off >> ALIGN_W);
                o_wr.data = '{start: 1'b1, used: 1'b0, len: r_len[LEN_W-1:0]};
                n_off     = nxt;
                n_steps   = r_steps + 1'b1;
                n_state   = S_MG_RD;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end
endmodule

// ===== verif/first_fit_pool_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_tb
// self-checking bench: a directed table of requests, then random traffic
// built mostly from well-formed allocate/free/merge requests, each response
// checked against a behavioral pool model or a fixed expected value, with
// random idling on both sides
module first_fit_pool_allocator_tb;
    import ffpa_pkg::*;

    localparam int N_RANDOM   = 850;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 2500;

    typedef struct {
        t_kind       kind;
        logic [15:0] size;
        logic [11:0] addr;
        bit          fixed;
        t_status     st;
        logic [11:0] gaddr;
    } t_row;

    typedef struct {
        t_status     st;
        logic [11:0] gaddr;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ffpa_req_if req_if ();
    ffpa_rsp_if rsp_if ();

    first_fit_pool_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pool model
    bit      seg_start [GRANULES];
    bit      seg_used  [GRANULES];
    int      seg_len   [GRANULES];
    t_answer answer_q[$];
    int      live_q[$];
    bit      fail_seen = 0;
    bit      stim_done = 0;
    int      idle_cycles = 0;

    bit          cur_fixed = 0;
    t_status     cur_st = ST_OK;
    logic [11:0] cur_gaddr = '0;

    function automatic int round_align(int x);
        return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic void pool_clear();
        for (int g = 0; g < GRANULES; g++) begin
            seg_start[g] = 0;
            seg_used[g] = 0;
            seg_len[g] = 0;
        end
        seg_start[0] = 1;
        seg_len[0] = POOL_BYTES;
    endfunction

    function automatic t_answer pool_allocate(int size);
        t_answer a;
        int need, off, steps, g, rest, ng;
        need = round_align(size + HDR_BYTES);
        off = 0;
        steps = 0;
        a.st = ST_NOFIT;
        a.gaddr = '0;
        while (off < POOL_BYTES && steps < GRANULES) begin
            g = off / ALIGN_BYTES;
            if (seg_len[g] == 0) break;
            if (!seg_used[g] && seg_len[g] >= need) begin
                rest = seg_len[g] - need;
                if (rest <= HDR_BYTES) begin
                    need = seg_len[g];
                end else begin
                    ng = (off + need) / ALIGN_BYTES;
                    if (ng < GRANULES) begin
                        seg_start[ng] = 1;
                        seg_used[ng] = 0;
                        seg_len[ng] = rest;
                    end
                end
                seg_used[g] = 1;
                seg_len[g] = need;
                a.st = ST_OK;
                a.gaddr = 12'((off + HDR_BYTES) & 'hFFF);
                return a;
            end
            off += seg_len[g];
            steps++;
        end
        return a;
    endfunction

    function automatic t_status pool_release(int addr);
        int seg, g;
        if (addr < HDR_BYTES) return ST_BADADDR;
        seg = addr - HDR_BYTES;
        if (seg >= POOL_BYTES || (seg % ALIGN_BYTES) != 0) return ST_BADADDR;
        g = seg / ALIGN_BYTES;
        if (g >= GRANULES || !seg_start[g]) return ST_BADADDR;
        seg_used[g] = 0;
        return ST_OK;
    endfunction

    function automatic void pool_merge();
        int off, steps, g, nxt, ng;
        off = 0;
        steps = 0;
        while (off < POOL_BYTES && steps < GRANULES) begin
            g = off / ALIGN_BYTES;
            if (seg_len[g] == 0) break;
            if (!seg_used[g]) begin
                forever begin
                    nxt = off + seg_len[g];
                    if (nxt >= POOL_BYTES || (nxt % ALIGN_BYTES) != 0) break;
                    ng = nxt / ALIGN_BYTES;
                    if (ng >= GRANULES || !seg_start[ng] || seg_used[ng]) break;
                    if (seg_len[ng] == 0) break;
                    seg_len[g] += seg_len[ng];
                    seg_start[ng] = 0;
                    seg_len[ng] = 0;
                end
            end
            off += seg_len[g];
            steps++;
        end
    endfunction

    // request acceptance, response check, watchdog
    always @(posedge i_clk) begin
        t_answer a, e;
        if (req_if.valid && req_if.ready) begin
            a.st = ST_OK;
            a.gaddr = '0;
            case (t_kind'(req_if.kind))
                K_ALLOC: begin
                    a = pool_allocate(int'(req_if.request_size));
                    if (a.st == ST_OK) live_q.push_back(int'(a.gaddr));
                end
                K_FREE:   a.st = pool_release(int'(req_if.block_address));
                K_MERGE:  pool_merge();
                K_REINIT: begin
                    pool_clear();
                    live_q.delete();
                end
            endcase
            if (cur_fixed) begin
                a.st = cur_st;
                a.gaddr = cur_gaddr;
            end
            answer_q.push_back(a);
        end
        if (rsp_if.valid && rsp_if.ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t unexpected word: status %0d addr %0d", $time,
                         rsp_if.status, rsp_if.granted_address);
                fail_seen = 1;
            end else begin
                e = answer_q.pop_front();
                if (rsp_if.status !== e.st) begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             e.st, rsp_if.status);
                    fail_seen = 1;
                end
                if (rsp_if.granted_address !== e.gaddr) begin
                    $display("%0t granted_address mismatch: expected %0d actual %0d",
                             $time, e.gaddr, rsp_if.granted_address);
                    fail_seen = 1;
                end
            end
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || !i_rst_n || (stim_done && answer_q.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t watchdog expired", $time);
            $display("** first_fit_pool_allocator: FAILED **");
            $finish;
        end
    end

    // response side stalls
    int  rsp_wait = 0;
    bit  rsp_burst = 0;
    initial rsp_if.ready = 1'b0;
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_if.valid && rsp_if.ready) begin
            if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
            w = rsp_burst ? 0 : $urandom_range(0, 5);
            rsp_wait = w;
            rsp_if.ready <= (w == 0);
        end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_if.ready <= (rsp_wait == 0);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // request side
    bit req_burst = 0;

    task automatic send_word(t_row r);
        int gap;
        if ($urandom_range(0, 49) == 0) req_burst = !req_burst;
        gap = req_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind <= r.kind;
        req_if.request_size <= r.size;
        req_if.block_address <= r.addr;
        cur_fixed <= r.fixed;
        cur_st <= r.st;
        cur_gaddr <= r.gaddr;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    function automatic t_row make_random();
        t_row r;
        int p, q;
        r.fixed = 0;
        r.st = ST_OK;
        r.gaddr = '0;
        r.size = 16'($urandom);
        r.addr = 12'($urandom);
        p = $urandom_range(0, 99);
        if (p < 45) begin
            r.kind = K_ALLOC;
            q = $urandom_range(0, 99);
            if (q < 90) r.size = 16'($urandom_range(0, 200));
            else if (q < 97) r.size = 16'($urandom_range(0, POOL_BYTES));
        end else if (p < 80) begin
            r.kind = K_FREE;
            if (live_q.size() > 0 && $urandom_range(0, 99) < 85)
                r.addr = 12'(live_q[$urandom_range(0, live_q.size() - 1)]);
        end else if (p < 96) begin
            r.kind = K_MERGE;
        end else begin
            r.kind = K_REINIT;
        end
        return r;
    endfunction

    t_row table_rows[$];

    initial begin
        req_if.valid = 1'b0;
        req_if.kind = K_ALLOC;
        req_if.request_size = '0;
        req_if.block_address = '0;

        table_rows = '{
            '{K_ALLOC,  16'd0,     12'd0,    1, ST_OK,      12'd16},
            '{K_ALLOC,  16'hFFFF,  12'hFFF,  1, ST_NOFIT,   12'd0},
            '{K_FREE,   16'hFFFF,  12'd0,    1, ST_BADADDR, 12'd0},
            '{K_FREE,   16'd0,     12'hFFF,  1, ST_BADADDR, 12'd0},
            '{K_FREE,   16'd0,     12'd18,   1, ST_BADADDR, 12'd0},
            '{K_FREE,   16'd0,     12'd16,   1, ST_OK,      12'd0},
            '{K_FREE,   16'd0,     12'd16,   1, ST_OK,      12'd0},
            '{K_MERGE,  16'hFFFF,  12'hFFF,  1, ST_OK,      12'd0},
            '{K_FREE,   16'd0,     12'd48,   0, ST_OK,      12'd0},
            '{K_ALLOC,  16'd5,     12'd0,    0, ST_OK,      12'd0},
            '{K_ALLOC,  16'd100,   12'd0,    0, ST_OK,      12'd0},
            '{K_ALLOC,  16'd3,     12'd0,    0, ST_OK,      12'd0},
            '{K_FREE,   16'd0,     12'd16,   0, ST_OK,      12'd0},
            '{K_FREE,   16'd0,     12'd40,   0, ST_OK,      12'd0},
            '{K_MERGE,  16'd0,     12'd0,    1, ST_OK,      12'd0},
            '{K_FREE,   16'd0,     12'd40,   0, ST_OK,      12'd0},
            '{K_REINIT, 16'hFFFF,  12'hFFF,  1, ST_OK,      12'd0},
            '{K_ALLOC,  16'd4080,  12'd0,    1, ST_OK,      12'd16},
            '{K_ALLOC,  16'd0,     12'd0,    1, ST_NOFIT,   12'd0},
            '{K_REINIT, 16'd0,     12'd0,    1, ST_OK,      12'd0},
            '{K_ALLOC,  16'd4081,  12'd0,    1, ST_NOFIT,   12'd0},
            '{K_ALLOC,  16'd4064,  12'd0,    0, ST_OK,      12'd0},
            '{K_ALLOC,  16'd0,     12'd0,    0, ST_OK,      12'd0},
            '{K_REINIT, 16'd0,     12'd0,    1, ST_OK,      12'd0}
        };

        pool_clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) send_word(table_rows[i]);
        repeat (N_RANDOM) send_word(make_random());
        req_if.valid <= 1'b0;
        cur_fixed <= 1'b0;
        stim_done = 1;

        while (answer_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (!fail_seen && answer_q.size() == 0) begin
            $display("** first_fit_pool_allocator: PASSED **");
        end else begin
            $display("** first_fit_pool_allocator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ffpa_pkg.sv
hdl/ffpa_if.sv
hdl/ffpa_ram.sv
hdl/ffpa_ctrl.sv
hdl/first_fit_pool_allocator.sv
verif/first_fit_pool_allocator_tb.sv
